@@ hw/rtl/console_line_editor_top_macros.svh @@
// assertion macros shared by the console line editor rtl
`ifndef CONSOLE_LINE_EDITOR_TOP_MACROS_SVH
`define CONSOLE_LINE_EDITOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define CLE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent checked in the cycle after the antecedent
`define CLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/cle_pkg.sv @@
// types and constants of the console line editor
`timescale 1ns / 1ps
package cle_pkg;

	// default line store depth
	localparam int LINE_DEPTH_DEF = 128;

	// action codes
	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_KEY   = 2'd1;
	localparam logic [1:0] ACT_CLAIM = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	// editor modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_NEED = 2'd1;
	localparam logic [1:0] MODE_GOT  = 2'd2;
	localparam logic [1:0] MODE_RUN  = 2'd3;

	// echo item counts
	localparam logic [1:0] ECHO_NONE  = 2'd0;
	localparam logic [1:0] ECHO_ONE   = 2'd1;
	localparam logic [1:0] ECHO_ERASE = 2'd3;

	// special bytes
	localparam logic [7:0] BYTE_IGNORED = 8'hFF;
	localparam logic [7:0] BYTE_BS      = 8'h08;
	localparam logic [7:0] BYTE_CR      = 8'h0D;
	localparam logic [7:0] BYTE_LF      = 8'h0A;
	localparam logic [7:0] BYTE_SPACE   = 8'h20;
	localparam logic [7:0] BYTE_SQ      = 8'h27;
	localparam logic [7:0] BYTE_DQ      = 8'h22;
	localparam logic [7:0] LOWER_FIRST  = 8'h61;
	localparam logic [7:0] LOWER_LAST   = 8'h7A;
	localparam logic [7:0] CASE_SHIFT   = 8'h20;

	// register byte addresses
	localparam logic [2:0] REG_CAPACITY = 3'd0;
	localparam logic [2:0] REG_ECHO     = 3'd4;

	// register reset values
	localparam logic [6:0] CAPACITY_RST = 7'd127;
	localparam logic       ECHO_RST     = 1'b1;

	// input item
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] key;
		logic [6:0] position;
	} cle_in_t;

	// result item
	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       line_ready;
		logic       claimed;
		logic [6:0] cursor_pos;
		logic       last;
	} cle_out_t;

	// line store access
	typedef struct packed {
		logic       we;
		logic       re;
		logic [6:0] idx;
		logic [7:0] wdata;
	} cle_mem_req_t;

	// finished input, handed to the result sequencer
	typedef struct packed {
		logic [1:0] echo_n;
		logic [7:0] echo_byte;
		logic [7:0] value;
		logic       line_ready;
		logic       claimed;
		logic [6:0] cursor_pos;
	} cle_desc_t;

endpackage

@@ hw/rtl/cle_store.sv @@
// line store memory with registered read data
`timescale 1ns / 1ps
module cle_store #(
	parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
	input  logic                  clk,
	input  cle_pkg::cle_mem_req_t req,
	output logic [7:0]            rdata
);
	import cle_pkg::*;

	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [7:0]    mem [LINE_DEPTH];
	logic [7:0]    rdata_q;
	logic          rd_ok_q;
	logic          in_range;
	logic [AW-1:0] addr;

	// index check against the store depth
	assign in_range = (32'(req.idx) < 32'(LINE_DEPTH));
	assign addr     = AW'(req.idx);

	// single port: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (req.we && in_range) begin
			mem[addr] <= req.wdata;
		end
		if (req.re) begin
			rd_ok_q <= in_range;
			if (in_range) begin
				rdata_q <= mem[addr];
			end
		end
	end

	// reads outside the store answer zero
	assign rdata = rd_ok_q ? rdata_q : 8'd0;

endmodule

@@ hw/rtl/cle_edit.sv @@
// editor state, key decode and the store access stage
`timescale 1ns / 1ps
`include "console_line_editor_top_macros.svh"
module cle_edit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cle_pkg::cle_in_t      cmd,
	input  logic [6:0]            line_capacity,
	input  logic                  echo_enable,
	output cle_pkg::cle_mem_req_t mem_req,
	input  logic [7:0]            mem_rdata,
	output logic                  desc_valid,
	output cle_pkg::cle_desc_t    desc,
	input  logic                  desc_take
);
	import cle_pkg::*;

	logic [6:0]   cursor_q, cursor_d;
	logic [1:0]   mode_q, mode_d;
	logic [7:0]   quote_q, quote_d;
	logic         accept;
	cle_mem_req_t req_d;
	cle_desc_t    desc_d;
	logic         bschk_d;
	logic         read_d;
	logic [7:0]   ch;

	logic         valid_s1;
	cle_desc_t    desc_s1;
	logic         bschk_s1;
	logic         read_s1;

	// a pending backspace must settle the quote state before the next item
	assign cmd_ready = (!valid_s1 || desc_take) && !(valid_s1 && bschk_s1);
	assign accept    = cmd_valid && cmd_ready;

	// decode of one input against the current state
	always_comb begin
		cursor_d = cursor_q;
		mode_d   = mode_q;
		quote_d  = quote_q;
		req_d    = '0;
		desc_d   = '0;
		bschk_d  = 1'b0;
		read_d   = 1'b0;
		ch       = cmd.key;
		case (cmd.action)
			ACT_BEGIN: begin
				mode_d   = MODE_NEED;
				cursor_d = 7'd0;
				quote_d  = 8'd0;
			end
			ACT_KEY: begin
				if (mode_q != MODE_IDLE && cmd.key != BYTE_IGNORED) begin
					if (cmd.key inside {BYTE_CR, BYTE_LF}) begin
						req_d.we         = 1'b1;
						req_d.idx        = cursor_q;
						req_d.wdata      = BYTE_LF;
						mode_d           = MODE_GOT;
						desc_d.echo_n    = ECHO_ONE;
						desc_d.echo_byte = BYTE_LF;
					end else if (cmd.key == BYTE_BS) begin
						if (cursor_q != 7'd0) begin
							cursor_d      = cursor_q - 7'd1;
							req_d.re      = 1'b1;
							req_d.idx     = cursor_q - 7'd1;
							bschk_d       = 1'b1;
							desc_d.echo_n = ECHO_ERASE;
						end
					end else if (cursor_q < line_capacity) begin
						if (cmd.key == quote_q) begin
							quote_d = 8'd0;
						end else if (cmd.key inside {BYTE_DQ, BYTE_SQ}) begin
							quote_d = cmd.key;
						end else if (quote_q == 8'd0 &&
							cmd.key inside {[LOWER_FIRST:LOWER_LAST]}) begin
							ch = cmd.key - CASE_SHIFT;
						end
						req_d.we         = 1'b1;
						req_d.idx        = cursor_q;
						req_d.wdata      = ch;
						cursor_d         = cursor_q + 7'd1;
						desc_d.echo_n    = ECHO_ONE;
						desc_d.echo_byte = ch;
					end
				end
				if (!echo_enable) begin
					desc_d.echo_n = ECHO_NONE;
				end
			end
			ACT_CLAIM: begin
				if (mode_q == MODE_GOT) begin
					mode_d         = MODE_RUN;
					desc_d.claimed = 1'b1;
				end
			end
			ACT_READ: begin
				req_d.re  = 1'b1;
				req_d.idx = cmd.position;
				read_d    = 1'b1;
			end
			default: begin
			end
		endcase
		desc_d.line_ready = (mode_d == MODE_GOT);
		desc_d.cursor_pos = cursor_d;
	end

	// store access only for an accepted item
	assign mem_req = accept ? req_d : '0;

	// editor state; a backspace clears the quote when the erased byte read back matches it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= 7'd0;
			mode_q   <= MODE_IDLE;
			quote_q  <= 8'd0;
		end else if (accept) begin
			cursor_q <= cursor_d;
			mode_q   <= mode_d;
			quote_q  <= quote_d;
		end else if (valid_s1 && bschk_s1 && mem_rdata == quote_q) begin
			quote_q <= 8'd0;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (desc_take) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1  <= desc_d;
			bschk_s1 <= bschk_d;
			read_s1  <= read_d;
		end
	end

	// read data joins the item here
	always_comb begin
		desc       = desc_s1;
		desc.value = read_s1 ? mem_rdata : 8'd0;
	end
	assign desc_valid = valid_s1;

	`CLE_ASSERT(a_bs_interlock, clk, arst_n, (valid_s1 && bschk_s1) |-> !cmd_ready, "backspace not interlocked")
	`CLE_ASSERT_NEXT(a_mode_kept, clk, arst_n, (mode_q != MODE_IDLE), (mode_q != MODE_IDLE), "mode fell back to idle")
	`CLE_ASSERT_NEXT(a_cursor_hold, clk, arst_n, (accept && (cmd.action == ACT_CLAIM || cmd.action == ACT_READ)), $stable(cursor_q), "cursor moved on claim or read")

endmodule

@@ hw/rtl/cle_emit.sv @@
// output register that sends echo bytes and the status item of one input
`timescale 1ns / 1ps
`include "console_line_editor_top_macros.svh"
module cle_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               desc_valid,
	input  cle_pkg::cle_desc_t desc,
	output logic               desc_take,
	output logic               res_valid,
	input  logic               res_ready,
	output cle_pkg::cle_out_t  res
);
	import cle_pkg::*;

	logic      em_valid_q;
	cle_desc_t em_q;
	logic [1:0] idx_q;
	logic      is_last;
	logic      xfer;

	assign is_last   = (idx_q == em_q.echo_n);
	assign res_valid = em_valid_q;
	assign xfer      = res_valid && res_ready;
	assign desc_take = !em_valid_q || (xfer && is_last);

	// item sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			idx_q      <= 2'd0;
		end else if (desc_valid && desc_take) begin
			em_valid_q <= 1'b1;
			idx_q      <= 2'd0;
		end else if (xfer) begin
			if (is_last) begin
				em_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// held input summary
	always_ff @(posedge clk) begin
		if (desc_valid && desc_take) begin
			em_q <= desc;
		end
	end

	// result fields of the current item
	always_comb begin
		res.kind       = is_last;
		res.line_ready = em_q.line_ready;
		res.claimed    = em_q.claimed;
		res.cursor_pos = em_q.cursor_pos;
		res.last       = is_last;
		if (is_last) begin
			res.value = em_q.value;
		end else if (em_q.echo_n == ECHO_ERASE) begin
			res.value = (idx_q == 2'd1) ? BYTE_SPACE : BYTE_BS;
		end else begin
			res.value = em_q.echo_byte;
		end
	end

	`CLE_ASSERT(a_idx_range, clk, arst_n, em_valid_q |-> (idx_q <= em_q.echo_n), "item index past status")
	`CLE_ASSERT_NEXT(a_idx_hold, clk, arst_n, (res_valid && !res_ready), (res_valid && $stable(idx_q)), "item index moved while stalled")

endmodule

@@ hw/rtl/console_line_editor_top.sv @@
// top level of the console line editor with its register port
`timescale 1ns / 1ps
// Console line editor. When an input item is accepted, its line
// store access (write of a typed byte, read of a stored character or of the
// byte erased by a backspace) goes to a single-port memory in that cycle;
// the item then passes the edit stage register and the output register,
// which offers the first result item, one result item per cycle while
// res_ready is high. An input gives one to four result items, all through
// the single result port, which sets the sustained input rate; a backspace
// also holds off the next input while the erased byte is compared with the
// open quote. The line store needs no clearing after reset.
module console_line_editor_top #(
	parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cle_pkg::cle_in_t  cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output cle_pkg::cle_out_t res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import cle_pkg::*;

	logic [6:0]   capacity_q;
	logic         echo_q;
	logic         cfg_wr;
	cle_mem_req_t mem_req;
	logic [7:0]   mem_rdata;
	logic         desc_valid;
	cle_desc_t    desc;
	logic         desc_take;

	// register port, byte lanes ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
			echo_q     <= ECHO_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ECHO[2]) begin
				echo_q <= pwdata[0];
			end else begin
				capacity_q <= pwdata[6:0];
			end
		end
	end

	// register readback
	assign prdata = (paddr[2] == REG_CAPACITY[2]) ? {25'd0, capacity_q} : {31'd0, echo_q};

	// editor state and store access
	cle_edit u_edit (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.line_capacity(capacity_q),
		.echo_enable  (echo_q),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.desc_valid   (desc_valid),
		.desc         (desc),
		.desc_take    (desc_take)
	);

	// line store
	cle_store #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_store (
		.clk  (clk),
		.req  (mem_req),
		.rdata(mem_rdata)
	);

	// result sequencing
	cle_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_valid(desc_valid),
		.desc      (desc),
		.desc_take (desc_take),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
